FILE: hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and codes for the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
package slc_pkg;

    // Access kinds carried on the mode field. Any other code acts as a load.
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_STORE  = 2'd1;
    localparam logic [1:0] MODE_MODIFY = 2'd2;

    // Result of the first lookup of an access.
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS        = 2'd2;

    // Widths of the configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Live configuration as seen by the controller.
    typedef struct packed {
        logic [2:0] set_bits;
        logic [4:0] offset_bits;
        logic [3:0] ways;
    } cfg_t;

    // One cache line as held in the set memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] stamp;
    } line_t;

endpackage

FILE: hdl/set_assoc_lru_cache_sim_top.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_top
// Set-associative cache model with LRU replacement: counts hits, misses
// and evictions of a stream of load, store and modify accesses.
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ------------------------------------
//   access    start high, busy low    mode, address
//   result    done (one-cycle beat)   outcome, second_hit, hit_total,
//                                     miss_total, eviction_total
//   config    wr_en                   wr_index, wr_data
//
// A hit or a fill reads the set row, then compares all ways and writes
// the row back before the next accept.
// An eviction adds a victim scan, one stamp compare per way in use beyond
// the first; a way count of zero counts as 1 and one above MAX_WAYS
// counts as MAX_WAYS.
// The result beat appears in the cycle after the row write-back.
// After reset the set memory is cleared one row a cycle, all 2^MAX_SET_BITS
// rows, with busy high; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_sim_top #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     mode,
    input  logic [31:0]                    address,
    output logic                           done,
    output logic [1:0]                     outcome,
    output logic                           second_hit,
    output logic [31:0]                    hit_total,
    output logic [31:0]                    miss_total,
    output logic [31:0]                    eviction_total,
    input  logic                           wr_en,
    input  logic [slc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [slc_pkg::CFG_DATA_W-1:0] wr_data
);
    import slc_pkg::*;

    localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH  = 1 << MAX_SET_BITS;

    cfg_t cfg_reg;

    logic                  ram_rd_en;
    logic [SET_AW-1:0]     ram_rd_addr;
    line_t [MAX_WAYS-1:0]  ram_rd_data;
    logic                  ram_wr_en;
    logic [SET_AW-1:0]     ram_wr_addr;
    line_t [MAX_WAYS-1:0]  ram_wr_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits    <= 3'd4;
            cfg_reg.offset_bits <= 5'd4;
            cfg_reg.ways        <= 4'd1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SET_BITS:    cfg_reg.set_bits    <= wr_data[2:0];
                REG_OFFSET_BITS: cfg_reg.offset_bits <= wr_data;
                REG_WAYS:        cfg_reg.ways        <= wr_data[3:0];
                default:         ;
            endcase
        end
    end

    // Access sequencer.
    slc_ctrl #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .SET_AW       (SET_AW),
        .DEPTH        (DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .start          (start),
        .mode           (mode),
        .address        (address),
        .busy           (busy),
        .done           (done),
        .outcome        (outcome),
        .second_hit     (second_hit),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data)
    );

    // Set memory.
    slc_set_ram #(
        .ADDR_W (SET_AW),
        .DEPTH  (DEPTH),
        .WAYS   (MAX_WAYS)
    ) u_set_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

endmodule

FILE: hdl/slc_set_ram.sv
// ----------------------------------------------------------------------------
// slc_set_ram
// Set memory: one row per set holding every way, one write port and one
// read port with a registered read that holds while no read is issued.
// ----------------------------------------------------------------------------
module slc_set_ram #(
    parameter int ADDR_W = 6,
    parameter int DEPTH  = 64,
    parameter int WAYS   = 8
) (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output slc_pkg::line_t [WAYS-1:0]     rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  slc_pkg::line_t [WAYS-1:0]     wr_data
);
    import slc_pkg::*;

    line_t [WAYS-1:0] mem [DEPTH];
    line_t [WAYS-1:0] rd_data_reg;

    // Row write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered row read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/slc_ctrl.sv
// ----------------------------------------------------------------------------
// slc_ctrl
// Access sequencer: splits the address, reads the set, compares all ways,
// scans stamps for the LRU victim on an eviction, writes the set back and
// keeps the stamp and the running totals. Clears the set memory after reset.
// ----------------------------------------------------------------------------
module slc_ctrl #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int SET_AW       = 6,
    parameter int DEPTH        = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  slc_pkg::cfg_t                 cfg,
    input  logic                          start,
    input  logic [1:0]                    mode,
    input  logic [31:0]                   address,
    output logic                          busy,
    output logic                          done,
    output logic [1:0]                    outcome,
    output logic                          second_hit,
    output logic [31:0]                   hit_total,
    output logic [31:0]                   miss_total,
    output logic [31:0]                   eviction_total,
    output logic                          ram_rd_en,
    output logic [SET_AW-1:0]             ram_rd_addr,
    input  slc_pkg::line_t [MAX_WAYS-1:0] ram_rd_data,
    output logic                          ram_wr_en,
    output logic [SET_AW-1:0]             ram_wr_addr,
    output slc_pkg::line_t [MAX_WAYS-1:0] ram_wr_data
);
    import slc_pkg::*;

    localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [4:0] WAYS_LIM = 5'(MAX_WAYS);
    localparam logic [3:0] SET_LIM  = 4'(MAX_SET_BITS);
    localparam logic [SET_AW-1:0] CLR_LAST = SET_AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_SCAN
    } state_t;

    state_t              state_reg, state_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [1:0]          outcome_reg, outcome_next;
    logic                second_reg, second_next;
    logic [31:0]         hits_reg, hits_next;
    logic [31:0]         misses_reg, misses_next;
    logic [31:0]         evict_reg, evict_next;
    logic [31:0]         stamp_reg, stamp_next;
    logic [SET_AW-1:0]   clr_reg, clr_next;
    logic [SET_AW-1:0]   set_reg, set_next;
    logic [31:0]         tag_reg, tag_next;
    logic                modify_reg, modify_next;
    logic [WIDX_W-1:0]   scan_reg, scan_next;
    logic [WIDX_W-1:0]   victim_reg, victim_next;
    logic [31:0]         min_reg, min_next;

    logic [3:0]          eff_sb;
    logic [5:0]          split_sum;
    logic [SET_AW-1:0]   set_mask;
    logic [SET_AW-1:0]   set_in;
    logic [31:0]         tag_in;
    logic [31:0]         shifted;
    logic [4:0]          eff_ways;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [WIDX_W-1:0]   hit_way;
    logic [WIDX_W-1:0]   inv_way;
    logic [31:0]         cand_stamp;
    logic                cand_less;
    logic                scan_last;
    logic                commit_en;
    logic [WIDX_W-1:0]   commit_way;
    logic [1:0]          commit_outcome;
    logic [31:0]         commit_stamp;
    line_t [MAX_WAYS-1:0] new_row;

    // Address split under the live configuration.
    always_comb
    begin
        eff_sb    = ({1'b0, cfg.set_bits} > SET_LIM) ? SET_LIM : {1'b0, cfg.set_bits};
        split_sum = {2'b00, eff_sb} + {1'b0, cfg.offset_bits};
        set_mask  = ~({SET_AW{1'b1}} << eff_sb);
        shifted   = address >> cfg.offset_bits;
        set_in    = shifted[SET_AW-1:0] & set_mask;
        tag_in    = (split_sum >= 6'd32) ? 32'd0 : (address >> split_sum[4:0]);
    end

    // Effective associativity.
    always_comb
    begin
        if (cfg.ways == 4'd0)
        begin
            eff_ways = 5'd1;
        end
        else if ({1'b0, cfg.ways} > WAYS_LIM)
        begin
            eff_ways = WAYS_LIM;
        end
        else
        begin
            eff_ways = {1'b0, cfg.ways};
        end
    end

    // Parallel tag compare and first-invalid search over the read row.
    always_comb
    begin
        hit_way = '0;
        inv_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            hit_vec[w] = (5'(w) < eff_ways) && ram_rd_data[w].valid
                         && (ram_rd_data[w].tag == tag_reg);
            inv_vec[w] = (5'(w) < eff_ways) && !ram_rd_data[w].valid;
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_way = WIDX_W'(w);
            end
            if (inv_vec[w])
            begin
                inv_way = WIDX_W'(w);
            end
        end
    end

    // One stamp compare per cycle during the victim scan.
    always_comb
    begin
        cand_stamp = ram_rd_data[scan_reg].stamp;
        cand_less  = cand_stamp < min_reg;
        scan_last  = (5'(scan_reg) == (eff_ways - 5'd1));
    end

    // Decide when and where the set is updated.
    always_comb
    begin
        commit_en      = 1'b0;
        commit_way     = '0;
        commit_outcome = OUT_HIT;
        if (state_reg == ST_LOOK)
        begin
            if (|hit_vec)
            begin
                commit_en  = 1'b1;
                commit_way = hit_way;
            end
            else if (|inv_vec)
            begin
                commit_en      = 1'b1;
                commit_way     = inv_way;
                commit_outcome = OUT_FILL;
            end
            else if (eff_ways == 5'd1)
            begin
                commit_en      = 1'b1;
                commit_outcome = OUT_EVICT;
            end
        end
        else if (state_reg == ST_SCAN && scan_last)
        begin
            commit_en      = 1'b1;
            commit_way     = cand_less ? scan_reg : victim_reg;
            commit_outcome = OUT_EVICT;
        end
    end

    // New row: the chosen way takes the tag and the newest stamp.
    // A modify access stamps its guaranteed second hit as well.
    always_comb
    begin
        commit_stamp = stamp_reg + (modify_reg ? 32'd2 : 32'd1);
        new_row      = ram_rd_data;
        new_row[commit_way].valid = 1'b1;
        new_row[commit_way].tag   = tag_reg;
        new_row[commit_way].stamp = commit_stamp;
    end

    // Memory ports.
    always_comb
    begin
        ram_rd_en   = (state_reg == ST_IDLE) && start;
        ram_rd_addr = set_in;
        ram_wr_en   = (state_reg == ST_CLEAR) || commit_en;
        ram_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : set_reg;
        ram_wr_data = (state_reg == ST_CLEAR) ? '0 : new_row;
    end

    // Next-state logic.
    always_comb
    begin
        state_next   = state_reg;
        done_next    = commit_en;
        outcome_next = outcome_reg;
        second_next  = second_reg;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        evict_next   = evict_reg;
        stamp_next   = stamp_reg;
        clr_next     = clr_reg;
        set_next     = set_reg;
        tag_next     = tag_reg;
        modify_next  = modify_reg;
        scan_next    = scan_reg;
        victim_next  = victim_reg;
        min_next     = min_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    set_next    = set_in;
                    tag_next    = tag_in;
                    modify_next = (mode == MODE_MODIFY);
                    state_next  = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!commit_en)
                begin
                    scan_next   = WIDX_W'(1);
                    victim_next = '0;
                    min_next    = ram_rd_data[0].stamp;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cand_less)
                begin
                    victim_next = scan_reg;
                    min_next    = cand_stamp;
                end
                scan_next = scan_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Update totals and stamp, and finish the access.
        if (commit_en)
        begin
            state_next   = ST_IDLE;
            outcome_next = commit_outcome;
            second_next  = modify_reg;
            stamp_next   = commit_stamp;
            hits_next    = hits_reg + {31'd0, commit_outcome == OUT_HIT}
                           + {31'd0, modify_reg};
            misses_next  = misses_reg + {31'd0, commit_outcome != OUT_HIT};
            evict_next   = evict_reg + {31'd0, commit_outcome == OUT_EVICT};
        end
        busy_next = (state_next != ST_IDLE);
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            outcome_reg <= OUT_HIT;
            second_reg  <= 1'b0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            evict_reg   <= '0;
            stamp_reg   <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            outcome_reg <= outcome_next;
            second_reg  <= second_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
            evict_reg   <= evict_next;
            stamp_reg   <= stamp_next;
            clr_reg     <= clr_next;
        end
    end

    // Access payload registers.
    always_ff @(posedge clk)
    begin
        set_reg    <= set_next;
        tag_reg    <= tag_next;
        modify_reg <= modify_next;
        scan_reg   <= scan_next;
        victim_reg <= victim_next;
        min_reg    <= min_next;
    end

    assign busy           = busy_reg;
    assign done           = done_reg;
    assign outcome        = outcome_reg;
    assign second_hit     = second_reg;
    assign hit_total      = hits_reg;
    assign miss_total     = misses_reg;
    assign eviction_total = evict_reg;

`ifndef SYNTHESIS
    // An accepted access never completes in the following cycle.
    a_no_early_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (!done && busy))
        else $error("result beat too early after accept");

    // The result beat coincides with the block going idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    // Miss and eviction totals move only with a miss result.
    a_miss_total: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(miss_total) || !$stable(eviction_total))
        |-> (done && outcome != OUT_HIT))
        else $error("miss totals changed without a miss beat");

    // The hit total moves only with a result beat.
    a_hit_total: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(hit_total) |-> done)
        else $error("hit total changed without a beat");

    // Reads and writes of the set memory never share a cycle.
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_rd_en && ram_wr_en))
        else $error("set memory read and write collide");
`endif

endmodule

FILE: bench/tb_set_assoc_lru_cache_sim_top.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_cache_sim_top
// Self-checking bench for the set-associative LRU cache model. A shadow copy
// of the set memory and the counters predicts every result beat. Directed
// accesses cover the address split extremes and LRU victim choice. Random
// traffic then runs through many cache geometries with sender gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_sim_top;

    import slc_pkg::*;

    localparam int SET_BITS_MAX = 6;
    localparam int WAYS_MAX     = 8;
    localparam int LINE_COUNT   = (1 << SET_BITS_MAX) * WAYS_MAX;

    // The mode code that has no meaning of its own and acts as a load.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One expected result beat.
    typedef struct packed {
        logic [1:0]  outcome;
        logic        second_hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } cache_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            mode;
    logic [31:0]           address;
    logic                  done;
    logic [1:0]            outcome;
    logic                  second_hit;
    logic [31:0]           hit_total;
    logic [31:0]           miss_total;
    logic [31:0]           eviction_total;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    // Shadow cache state.
    cfg_t        shadow_cfg;
    logic        shadow_valid [LINE_COUNT];
    logic [31:0] shadow_tag   [LINE_COUNT];
    logic [31:0] shadow_stamp [LINE_COUNT];
    logic [31:0] stamp_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] evict_count;

    cache_result_t pending_results [$];
    int            error_count;
    int            accesses_sent;
    int            beats_checked;
    int            settings_count;

    set_assoc_lru_cache_sim_top #(
        .MAX_SET_BITS (SET_BITS_MAX),
        .MAX_WAYS     (WAYS_MAX)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .address        (address),
        .done           (done),
        .outcome        (outcome),
        .second_hit     (second_hit),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow cache
    // ------------------------------------------------------------------

    function automatic void clear_shadow();
        shadow_cfg.set_bits    = 3'd4;
        shadow_cfg.offset_bits = 5'd4;
        shadow_cfg.ways        = 4'd1;
        foreach (shadow_valid[i])
        begin
            shadow_valid[i] = 1'b0;
        end
        stamp_count = '0;
        hit_count   = '0;
        miss_count  = '0;
        evict_count = '0;
    endfunction

    function automatic int unsigned set_bits_now();
        return (shadow_cfg.set_bits > SET_BITS_MAX) ? SET_BITS_MAX : shadow_cfg.set_bits;
    endfunction

    function automatic int unsigned ways_now();
        if (shadow_cfg.ways == 0)
            return 1;
        return (shadow_cfg.ways > WAYS_MAX) ? WAYS_MAX : shadow_cfg.ways;
    endfunction

    // One lookup in one set: hit, fill of the first free way, or LRU replace.
    function automatic logic [1:0] probe_set(int unsigned set_idx, logic [31:0] tag);
        int unsigned n;
        int unsigned base;
        int unsigned victim;
        n      = ways_now();
        base   = set_idx * WAYS_MAX;
        victim = 0;
        for (int unsigned w = 0; w < n; w++)
        begin
            if (shadow_valid[base + w] && shadow_tag[base + w] == tag)
            begin
                hit_count++;
                stamp_count++;
                shadow_stamp[base + w] = stamp_count;
                return OUT_HIT;
            end
        end
        for (int unsigned w = 0; w < n; w++)
        begin
            if (!shadow_valid[base + w])
            begin
                miss_count++;
                stamp_count++;
                shadow_valid[base + w] = 1'b1;
                shadow_tag[base + w]   = tag;
                shadow_stamp[base + w] = stamp_count;
                return OUT_FILL;
            end
        end
        // Oldest stamp loses; on a tie the lowest way loses.
        for (int unsigned w = 1; w < n; w++)
        begin
            if (shadow_stamp[base + w] < shadow_stamp[base + victim])
                victim = w;
        end
        miss_count++;
        evict_count++;
        stamp_count++;
        shadow_tag[base + victim]   = tag;
        shadow_stamp[base + victim] = stamp_count;
        return OUT_EVICT;
    endfunction

    function automatic cache_result_t predict_access(logic [1:0] kind, logic [31:0] addr);
        cache_result_t res;
        int unsigned   sb;
        int unsigned   bb;
        logic [31:0]   tag;
        int unsigned   set_idx;
        sb      = set_bits_now();
        bb      = shadow_cfg.offset_bits;
        tag     = (sb + bb >= 32) ? 32'd0 : (addr >> (sb + bb));
        set_idx = (addr >> bb) & ((32'd1 << sb) - 32'd1);
        res.outcome    = probe_set(set_idx, tag);
        res.second_hit = (kind == MODE_MODIFY);
        // A modify access writes the line it just loaded, always a hit.
        if (kind == MODE_MODIFY)
            void'(probe_set(set_idx, tag));
        res.hit_total      = hit_count;
        res.miss_total     = miss_count;
        res.eviction_total = evict_count;
        return res;
    endfunction

    // Assemble an address from tag, set and offset under the current split.
    function automatic logic [31:0] build_address(logic [31:0] tag, int unsigned set_pick,
                                                  logic [31:0] offs);
        int unsigned sb;
        int unsigned bb;
        logic [63:0] full;
        sb   = set_bits_now();
        bb   = shadow_cfg.offset_bits;
        full = ({32'd0, tag} << (sb + bb))
             | ((64'(set_pick) & ((64'd1 << sb) - 64'd1)) << bb)
             | ({32'd0, offs} & ((64'd1 << bb) - 64'd1));
        return full[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Present one access and hold it until the block takes the beat.
    task automatic send_access(input logic [1:0] kind, input logic [31:0] addr);
        start   <= 1'b1;
        mode    <= kind;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_access(kind, addr));
        accesses_sent++;
    endtask

    // Random sender gap before the next access.
    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [4:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_SET_BITS:    shadow_cfg.set_bits    = data[2:0];
            REG_OFFSET_BITS: shadow_cfg.offset_bits = data[4:0];
            REG_WAYS:        shadow_cfg.ways        = data[3:0];
            default:         ;
        endcase
    endtask

    // Only called with the block idle.
    task automatic apply_config(input logic [4:0] set_data, input logic [4:0] offset_data,
                                input logic [4:0] ways_data);
        write_reg(REG_SET_BITS, set_data);
        write_reg(REG_OFFSET_BITS, offset_data);
        write_reg(REG_WAYS, ways_data);
        wr_en <= 1'b0;
        @(posedge clk);
        settings_count++;
    endtask

    // ------------------------------------------------------------------
    // Result checking: every done beat against the oldest prediction
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        cache_result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            beats_checked++;
            if (pending_results.size() == 0)
            begin
                flag_error("result beat with no access outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                if (outcome !== want.outcome)
                    flag_error($sformatf("outcome got %0d want %0d", outcome, want.outcome));
                if (second_hit !== want.second_hit)
                    flag_error($sformatf("second_hit got %0b want %0b",
                                         second_hit, want.second_hit));
                if (hit_total !== want.hit_total)
                    flag_error($sformatf("hit_total got %0d want %0d",
                                         hit_total, want.hit_total));
                if (miss_total !== want.miss_total)
                    flag_error($sformatf("miss_total got %0d want %0d",
                                         miss_total, want.miss_total));
                if (eviction_total !== want.eviction_total)
                    flag_error($sformatf("eviction_total got %0d want %0d",
                                         eviction_total, want.eviction_total));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry: 16 sets, 16-byte blocks, direct mapped.
    task automatic test_basic_lookup();
        send_access(MODE_LOAD, 32'h0000_0000);    // fill set 0
        send_access(MODE_LOAD, 32'h0000_000F);    // same block, hit
        send_access(MODE_STORE, 32'h0000_0010);   // fill set 1
        send_access(MODE_MODIFY, 32'h0000_0100);  // conflict in set 0, evict
        send_access(MODE_SPARE, 32'h0000_0000);   // spare code behaves as a load
        send_access(MODE_LOAD, 32'hFFFF_FFFF);    // fill set 15, all-ones tag
        wait_idle();
    endtask

    // Address split extremes, then a full eight-way set to check LRU order.
    task automatic test_split_extremes();
        // Set bits above the maximum, widest offset, zero ways: tag is always
        // zero and the set comes from the top address bit alone.
        apply_config(5'd7, 5'd31, 5'd0);
        send_access(MODE_LOAD, 32'h0000_0000);
        send_access(MODE_LOAD, 32'h8000_0000);
        send_access(MODE_LOAD, 32'hFFFF_FFFF);
        send_access(MODE_MODIFY, 32'h7FFF_FFFF);
        wait_idle();

        // One set, byte blocks, way count above the maximum.
        apply_config(5'b11000, 5'd0, 5'd31);
        for (int i = 0; i < WAYS_MAX; i++)
            send_access(MODE_LOAD, 32'(i));
        send_access(MODE_LOAD, 32'd0);      // refresh way 0
        send_access(MODE_LOAD, 32'd8);      // evicts way 1, the oldest
        send_access(MODE_MODIFY, 32'd1);    // evicts way 2, now the oldest
        wait_idle();
    endtask

    // Random accesses over a series of random geometries. Most addresses come
    // from a small pool of tags and sets so that hits and evictions are common.
    task automatic test_random_traffic(input int idle_pct, input int phases,
                                       input int per_phase);
        logic [31:0] tag_pool [11];
        logic [31:0] addr;
        logic [1:0]  kind;
        logic [4:0]  set_data;
        logic [4:0]  offset_data;
        logic [4:0]  ways_data;
        for (int p = 0; p < phases; p++)
        begin
            set_data    = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 3));
            offset_data = 5'($urandom());
            ways_data   = ($urandom_range(0, 3) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 8));
            wait_idle();
            apply_config(set_data, offset_data, ways_data);
            foreach (tag_pool[i])
                tag_pool[i] = $urandom();
            for (int i = 0; i < per_phase; i++)
            begin
                sender_gap(idle_pct);
                kind = 2'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 15)
                    addr = $urandom();
                else
                    addr = build_address(tag_pool[$urandom_range(0, ways_now() + 2)],
                                         $urandom_range(0, 3), $urandom());
                send_access(kind, addr);
                // Now and then hold off until the block has drained.
                if ($urandom_range(0, 63) == 0)
                    wait_idle();
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        start         <= 1'b0;
        mode          <= MODE_LOAD;
        address       <= '0;
        wr_en         <= 1'b0;
        wr_index      <= REG_SET_BITS;
        wr_data       <= '0;
        error_count    = 0;
        accesses_sent  = 0;
        beats_checked  = 0;
        settings_count = 1;
        clear_shadow();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_lookup();
        test_split_extremes();
        test_random_traffic(14, 6, 100);
        test_random_traffic(46, 6, 100);
        test_random_traffic(0, 6, 100);

        wait_idle();
        repeat (32) @(posedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d accesses over %0d cache geometries, %0d result beats checked.",
                 accesses_sent, settings_count, beats_checked);
        $display("Predicted totals: %0d hits, %0d misses, %0d evictions.",
                 hit_count, miss_count, evict_count);
        if (error_count == 0)
            $display("tb_set_assoc_lru_cache_sim_top: done, clean");
        else
            $display("tb_set_assoc_lru_cache_sim_top: done, errors");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("tb_set_assoc_lru_cache_sim_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/slc_pkg.sv
hdl/slc_set_ram.sv
hdl/slc_ctrl.sv
hdl/set_assoc_lru_cache_sim_top.sv
bench/tb_set_assoc_lru_cache_sim_top.sv
